// ----- rtl/core/dsf_pkg.sv -----
// dsf_pkg: shared types and framing constants for the dle/stx framer
// no dependencies
`timescale 1ns / 1ps

package dsf_pkg;

    localparam logic [7:0] DLE = 8'h10;
    localparam logic [7:0] STX = 8'h02;
    localparam logic [7:0] ETX = 8'h03;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // one classified request, passed from the front end to the back end
    typedef struct packed {
        logic [7:0]  data;
        logic        open;
        logic        last;
        logic [15:0] crc;
    } cmd_t;

endpackage

// ----- rtl/core/dsf_front.sv -----
// dsf_front: accepts payload bytes, tracks frame state and runs the crc
// depends on dsf_pkg
`timescale 1ns / 1ps

module dsf_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        payload_byte,
    input  logic              last_byte,
    output dsf_pkg::cmd_t     cmd
);
    import dsf_pkg::*;

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_base;
    logic [15:0] crc_new;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // a new frame restarts the crc from zero
    assign crc_base = in_frame_reg ? crc_reg : 16'h0000;
    assign crc_new  = crc_byte(crc_base, payload_byte);

    assign cmd.data = payload_byte;
    assign cmd.open = ~in_frame_reg;
    assign cmd.last = last_byte;
    assign cmd.crc  = crc_new;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        if (accept)
        begin
            in_frame_next = ~last_byte;
            crc_next      = last_byte ? 16'h0000 : crc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            crc_reg      <= 16'h0000;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
        end
    end

endmodule

// ----- rtl/core/dsf_queue.sv -----
// dsf_queue: short register queue of classified requests between front and back
// depends on dsf_pkg
`timescale 1ns / 1ps

module dsf_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dsf_pkg::cmd_t     wr_cmd,
    output logic              full,
    input  logic              rd_en,
    output dsf_pkg::cmd_t     rd_cmd,
    output logic              empty
);
    import dsf_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    cmd_t            entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full   = (count_reg == CntW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

// ----- rtl/core/dsf_back.sv -----
// dsf_back: steps through the bytes of each queued request into the output register
// depends on dsf_pkg
`timescale 1ns / 1ps

module dsf_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  dsf_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic              frame_end
);
    import dsf_pkg::*;

    // byte sequence codes, in emission order
    localparam logic [2:0] S_DLE_OPEN  = 3'd0;
    localparam logic [2:0] S_STX       = 3'd1;
    localparam logic [2:0] S_PAYLOAD   = 3'd2;
    localparam logic [2:0] S_DLE_CLOSE = 3'd3;
    localparam logic [2:0] S_ETX       = 3'd4;
    localparam logic [2:0] S_CRC_HI    = 3'd5;
    localparam logic [2:0] S_CRC_LO    = 3'd6;

    logic       mid_reg;
    logic       mid_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [2:0] step_cur;
    logic       final_step;
    logic       slot_free;
    logic       emit;
    logic [7:0] byte_sel;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_fend_reg;

    assign step_cur   = mid_reg ? step_reg : (q_cmd.open ? S_DLE_OPEN : S_PAYLOAD);
    assign final_step = q_cmd.last ? (step_cur == S_CRC_LO) : (step_cur == S_PAYLOAD);
    assign slot_free  = ~out_valid_reg | pop;
    assign emit       = ~q_empty & slot_free;
    assign q_pop      = emit & final_step;

    always_comb
    begin
        unique case (step_cur)
            S_DLE_OPEN:  byte_sel = DLE;
            S_STX:       byte_sel = STX;
            S_PAYLOAD:   byte_sel = q_cmd.data;
            S_DLE_CLOSE: byte_sel = DLE;
            S_ETX:       byte_sel = ETX;
            S_CRC_HI:    byte_sel = q_cmd.crc[15:8];
            S_CRC_LO:    byte_sel = q_cmd.crc[7:0];
            default:     byte_sel = DLE;
        endcase
    end

    always_comb
    begin
        mid_next  = mid_reg;
        step_next = step_reg;
        if (emit)
        begin
            mid_next  = ~final_step;
            step_next = step_cur + 3'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (slot_free)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg       <= 1'b0;
            step_reg      <= S_DLE_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_reg       <= mid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= final_step;
            out_fend_reg <= (step_cur == S_CRC_LO);
        end
    end

    assign empty       = ~out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign frame_end   = out_fend_reg;

endmodule

// ----- rtl/core/dle_stx_framer_crc16.sv -----
// dle_stx_framer_crc16: dle/stx/etx framer with crc-16 (poly 0x1021, init 0)
// depends on dsf_pkg, dsf_front, dsf_queue, dsf_back
`timescale 1ns / 1ps

// input side is a queue write port: a payload byte with its last flag is taken
// on a clock edge with push high and full low. output side is a queue read
// port: while empty is low the oldest framed byte is on out_byte, last_of_run
// and frame_end, and pop high on that edge consumes it.
// each payload byte gives one to seven framed bytes: dle stx before the first
// byte of a frame, the byte itself, and dle etx crc_hi crc_lo after a byte
// flagged last. the crc covers payload bytes only.
// a taken byte is written into the request queue, then its first framed
// byte into the output register. the output advances one framed byte per
// cycle while the receiver keeps popping, so mid-frame one payload byte is
// taken per cycle; the byte sequencer in the back end sets the rate: a
// request that opens or closes a frame holds it until all its bytes are out.
// the request queue (QUEUE_DEPTH entries) raises full while the back end is
// busy or the receiver stalls; nothing is lost or dropped.
// reset clears the queue, the output register and the frame state: the next
// byte opens a new frame.

module dle_stx_framer_crc16
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] payload_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       frame_end
);
    import dsf_pkg::*;

    cmd_t front_cmd;
    cmd_t q_cmd;
    logic accept;
    logic q_empty;
    logic q_pop;

    assign accept = push & ~full;

    dsf_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .cmd          (front_cmd)
    );

    dsf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (q_pop),
        .rd_cmd (q_cmd),
        .empty  (q_empty)
    );

    dsf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule
